### hdl/tanimoto_fingerprint_score_core_assert.svh
// Assertion macros shared by the Tanimoto score core modules.
`ifndef TANIMOTO_FINGERPRINT_SCORE_CORE_ASSERT_SVH
`define TANIMOTO_FINGERPRINT_SCORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tfs_pkg.sv
// Shared constants, types and helper functions of the Tanimoto score core.
package tfs_pkg;

	localparam int MAX_BITS = 1024;
	localparam int WORD_W   = 64;
	localparam int PC_W     = $clog2(WORD_W + 1);
	localparam int CNT_W    = $clog2(MAX_BITS + 1);
	localparam int DEN_W    = CNT_W + 1;
	localparam int REM_W    = CNT_W + 2;
	localparam int ID_W     = 31;
	localparam int FRAC_W   = 16;
	localparam int SCORE_W  = FRAC_W + 1;
	localparam int STEP_W   = $clog2(SCORE_W);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_W;
	localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_BITS);

	// register index, taken from paddr[2]
	localparam logic REG_SCORE_CUTOFF = 1'b0;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] query_ones;
		logic [CNT_W-1:0] target_ones;
		logic [CNT_W-1:0] shared_ones;
	} tfs_totals_t;

	// SWAR population count; byte lanes never exceed 64 so no carries cross
	function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] s2;
		logic [WORD_W-1:0] s4;
		logic [WORD_W-1:0] s8;
		logic [WORD_W-1:0] s16;
		logic [WORD_W-1:0] s32;
		logic [WORD_W-1:0] s64;
		s2  = (w & 64'h5555_5555_5555_5555) + ((w >> 1) & 64'h5555_5555_5555_5555);
		s4  = (s2 & 64'h3333_3333_3333_3333) + ((s2 >> 2) & 64'h3333_3333_3333_3333);
		s8  = (s4 + (s4 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
		s16 = s8 + (s8 >> 8);
		s32 = s16 + (s16 >> 16);
		s64 = s32 + (s32 >> 32);
		return s64[PC_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] total,
	                                             input logic [PC_W-1:0] add);
		logic [DEN_W-1:0] sum;
		sum = {1'b0, total} + DEN_W'(add);
		return (sum > DEN_W'(MAX_BITS)) ? CNT_MAX : sum[CNT_W-1:0];
	endfunction

endpackage

### hdl/tfs_in_if.sv
// Word-pair input channel: valid/ready plus one fingerprint word pair.
interface tfs_in_if;
	import tfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] query_word;
	logic [WORD_W-1:0] target_word;
	logic [ID_W-1:0]   target_id;
	logic              last_word;

	modport source (output valid, query_word, target_word, target_id, last_word,
	                input ready);
	modport sink   (input valid, query_word, target_word, target_id, last_word,
	                output ready);
endinterface

### hdl/tfs_out_if.sv
// Score output channel: valid/ready plus one scored target.
interface tfs_out_if;
	import tfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    result_id;
	logic [SCORE_W-1:0] similarity;
	logic               meets_cutoff;

	modport source (output valid, result_id, similarity, meets_cutoff, input ready);
	modport sink   (input valid, result_id, similarity, meets_cutoff, output ready);
endinterface

### hdl/tanimoto_fingerprint_score_core.sv
// Top level of the Tanimoto fingerprint score core: front, queue, back, cutoff register.
//
//  channel  role    handshake          payload
//  -------  ------  -----------------  --------------------------------------------
//  item     sink    valid/ready        query_word, target_word, target_id, last_word
//  result   source  valid/ready        result_id, similarity, meets_cutoff
//  apb      slave   psel/penable/pwrite  score_cutoff at byte address 0
//
// Word beats are taken one per cycle; ready drops only when a last word sits in the
//   popcount stage and the two-entry totals queue is full.
// Each target passes through the back end in order: a pop, the one-bit-a-cycle restoring
//   divider, then a load of the result register.
// Result is registered; the divider starts the next target while it waits.
// Reset (arst_n low) clears the totals, queue, divider control and cutoff at once.
module tanimoto_fingerprint_score_core import tfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	tfs_in_if.sink            item,
	tfs_out_if.source         result
);

	logic [SCORE_W-1:0] cutoff_q;
	logic               cfg_write;
	tfs_totals_t        push_data;
	tfs_totals_t        head;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;

	// Config port: single register, index taken from paddr[2], low bits ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_SCORE_CUTOFF) ? DATA_W'(cutoff_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
		end else if (cfg_write && (paddr[2] == REG_SCORE_CUTOFF)) begin
			cutoff_q <= pwdata[SCORE_W-1:0];
		end
	end

	// Front: popcounts registered, then saturating totals; last word pushes a beat.
	tfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Queue decouples word streaming from the per-target division.
	tfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: shared/(query+target-shared) in Q1.16, empty pair scores 1.0.
	tfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.cutoff  (cutoff_q),
		.result  (result)
	);

endmodule

### hdl/tfs_front.sv
// Front end: popcount stage and saturating running totals, one beat a cycle unless stalled.
module tfs_front import tfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tfs_in_if.sink      item,
	output logic        push,
	output tfs_totals_t push_data,
	input  logic        q_full
);

	logic             valid_s1;
	logic             last_s1;
	logic [ID_W-1:0]  id_s1;
	logic [PC_W-1:0]  qpc_s1;
	logic [PC_W-1:0]  tpc_s1;
	logic [PC_W-1:0]  spc_s1;
	logic [CNT_W-1:0] qacc_q;
	logic [CNT_W-1:0] tacc_q;
	logic [CNT_W-1:0] sacc_q;
	logic             stall;
	logic             advance;
	logic [CNT_W-1:0] qnext;
	logic [CNT_W-1:0] tnext;
	logic [CNT_W-1:0] snext;

	// only a last word needs a queue slot
	assign stall      = valid_s1 && last_s1 && q_full;
	assign advance    = valid_s1 && !stall;
	assign item.ready = !stall;

	assign qnext = sat_add(qacc_q, qpc_s1);
	assign tnext = sat_add(tacc_q, tpc_s1);
	assign snext = sat_add(sacc_q, spc_s1);

	assign push      = advance && last_s1;
	assign push_data = '{id: id_s1, query_ones: qnext, target_ones: tnext,
	                     shared_ones: snext};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			last_s1 <= item.last_word;
			id_s1   <= item.target_id;
			qpc_s1  <= popcount(item.query_word);
			tpc_s1  <= popcount(item.target_word);
			spc_s1  <= popcount(item.query_word & item.target_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qacc_q <= '0;
			tacc_q <= '0;
			sacc_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				qacc_q <= '0;
				tacc_q <= '0;
				sacc_q <= '0;
			end else begin
				qacc_q <= qnext;
				tacc_q <= tnext;
				sacc_q <= snext;
			end
		end
	end

endmodule

### hdl/tfs_queue.sv
// Two-entry queue of finished totals between front end and divider.
module tfs_queue import tfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tfs_totals_t push_data,
	input  logic        pop,
	output tfs_totals_t head,
	output logic        full,
	output logic        empty
);
`include "tanimoto_fingerprint_score_core_assert.svh"

	tfs_totals_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TFS_ASSERT_IMP(a_no_overflow, push, !full, "push into full totals queue")
	`TFS_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty totals queue")
	`TFS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= QCNT_W'(QDEPTH),
		"totals queue count out of range")

endmodule

### hdl/tfs_back.sv
// Back end: restoring divider for the score and the registered result beat.
module tfs_back import tfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  tfs_totals_t        head,
	output logic               pop,
	input  logic [SCORE_W-1:0] cutoff,
	tfs_out_if.source          result
);
`include "tanimoto_fingerprint_score_core_assert.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [DEN_W-1:0]   den_q;
	logic [REM_W-1:0]   rem_q;
	logic [SCORE_W-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic [ID_W-1:0]    id_q;
	logic               zero_q;
	logic               out_valid_q;
	logic [ID_W-1:0]    out_id_q;
	logic [SCORE_W-1:0] out_sim_q;
	logic               out_meets_q;

	logic [DEN_W-1:0]   den_new;
	logic               fits;
	logic [REM_W-1:0]   rem_next;
	logic [SCORE_W-1:0] sim;
	logic               out_free;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	assign den_new = DEN_W'(head.query_ones) + DEN_W'(head.target_ones)
	               - DEN_W'(head.shared_ones);

	// one quotient bit per cycle; remainder kept pre-shifted for the next bit
	assign fits     = (rem_q >= REM_W'(den_q));
	assign rem_next = fits ? (rem_q - REM_W'(den_q)) : rem_q;

	assign sim = zero_q ? SCORE_ONE : ((quo_q > SCORE_ONE) ? SCORE_ONE : quo_q);

	assign out_free = !out_valid_q || result.ready;

	assign result.valid        = out_valid_q;
	assign result.result_id    = out_id_q;
	assign result.similarity   = out_sim_q;
	assign result.meets_cutoff = out_meets_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(SCORE_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					den_q  <= den_new;
					rem_q  <= REM_W'(head.shared_ones);
					quo_q  <= '0;
					step_q <= '0;
					id_q   <= head.id;
					zero_q <= (den_new == '0);
				end
			end
			ST_DIV: begin
				quo_q  <= {quo_q[SCORE_W-2:0], fits};
				rem_q  <= rem_next << 1;
				step_q <= step_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_id_q    <= id_q;
					out_sim_q   <= sim;
					out_meets_q <= (sim >= cutoff);
				end
			end
			default: begin
			end
		endcase
	end

	`TFS_ASSERT_IMP(a_sim_range, result.valid, result.similarity <= SCORE_ONE,
		"similarity above 1.0")
	`TFS_ASSERT_NXT(a_pop_starts_div, pop, state_q == ST_DIV,
		"pop did not start a division")
	`TFS_ASSERT_IMP(a_rem_bound, (state_q == ST_DIV) && !zero_q,
		rem_q < (REM_W'(den_q) << 1), "divider remainder out of range")

endmodule
